>>> rtl/dsq_pkg.sv
// ----------------------------------------------------------------------------
// dsq_pkg - shared types and codes for the delta sleep queue
// Request/result word layouts, request and status codes.
// ----------------------------------------------------------------------------
package dsq_pkg;

    localparam int unsigned TaskW  = 8;
    localparam int unsigned TicksW = 16;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_WOKEN     = 3'd1,
        ST_NONE_WOKE = 3'd2,
        ST_FULL      = 3'd3,
        ST_ZERO      = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [TaskW-1:0]  task_id;
        logic [TicksW-1:0] sleep_ticks;
    } t_in_word;

    typedef struct packed {
        logic [2:0]       status;
        logic [TaskW-1:0] woken_task;
        logic             last_result;
    } t_out_word;

endpackage

>>> rtl/dsq_front.sv
// ----------------------------------------------------------------------------
// dsq_front - request intake
// Drops unused request codes and holds a two-word queue towards the back end.
// ----------------------------------------------------------------------------
module dsq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  dsq_pkg::t_in_word i_word,
    output logic              o_q_valid,
    input  logic              i_q_take,
    output dsq_pkg::t_in_word o_q_word
);

    dsq_pkg::t_in_word r_mem [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall && (i_word.req_type != dsq_pkg::REQ_NONE);
    assign w_pop     = i_q_take && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_word;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

>>> rtl/dsq_back.sv
// ----------------------------------------------------------------------------
// dsq_back - delta-list engine
// Walks the list one entry at a time through a registered read port; shifts one
// entry at a time for insert/remove; finished words wait in a result register.
// ----------------------------------------------------------------------------
module dsq_back #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_take,
    input  dsq_pkg::t_in_word  i_q_word,
    output logic               o_valid,
    input  logic               i_stall,
    output dsq_pkg::t_out_word o_word
);

    localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned TW   = dsq_pkg::TaskW;
    localparam int unsigned DW   = dsq_pkg::TicksW;
    localparam logic [CntW-1:0] Full = CntW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_INS_CMP, S_INS_SHIFT, S_CAN_CMP, S_REM_SHIFT, S_TICK_CHK, S_OUT
    } t_state;

    // entry memories, single read port with registered data
    logic [TW-1:0]   r_task [QUEUE_DEPTH];
    logic [DW-1:0]   r_delta [QUEUE_DEPTH];
    logic [TW-1:0]   r_rd_task;
    logic [DW-1:0]   r_rd_delta;
    logic [IdxW-1:0] w_ra;
    logic            w_we;
    logic [IdxW-1:0] w_wa;
    logic [TW-1:0]   w_wt;
    logic [DW-1:0]   w_wd;

    t_state          r_state;
    logic [CntW-1:0] r_occ;
    logic [CntW-1:0] r_pos;     // walk / shift pointer
    logic [CntW-1:0] r_slot;    // insert position
    logic [DW-1:0]   r_rem;
    logic [TW-1:0]   r_tid;
    logic            r_ph;      // phase within a step (0 = read issued, 1 = data back)
    logic            r_first;   // tick decrement still to apply
    logic            r_woke;    // a released task waits to be reported
    logic [TW-1:0]   r_wtask;   // that task
    logic            r_after;   // resume the tick loop after the result
    dsq_pkg::t_out_word r_res;  // finished word, waiting for the output register
    dsq_pkg::t_out_word r_out;
    logic            r_ovalid;
    logic            w_load;
    logic            w_ins_go;
    logic [DW-1:0]   w_head;

    assign o_valid  = r_ovalid;
    assign o_word   = r_out;
    assign o_q_take = (r_state == S_IDLE);
    assign w_load   = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    assign w_ins_go = (r_pos < r_occ) && (r_rd_delta < r_rem);
    // head delta once this tick's decrement is applied (saturates at zero)
    assign w_head   = (r_first && r_rd_delta != '0) ? r_rd_delta - DW'(1) : r_rd_delta;

    // read address: pointer during walks, pointer-1 for insert shift, pointer+1
    // for remove shift, the head during a tick
    always_comb begin
        w_ra = r_pos[IdxW-1:0];
        case (r_state)
            S_INS_SHIFT: w_ra = IdxW'(r_pos - CntW'(1));
            S_REM_SHIFT: w_ra = IdxW'(r_pos + CntW'(1));
            S_TICK_CHK:  w_ra = '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_task  <= r_task[w_ra];
        r_rd_delta <= r_delta[w_ra];
        if (w_we) begin
            r_task[w_wa]  <= w_wt;
            r_delta[w_wa] <= w_wd;
        end
    end

    // Insert shift: pos starts at occ; each step reads pos-1, then
    // writes pos; the new entry goes in at the slot. Remove shift: reads pos+1
    // then writes pos.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_pos[IdxW-1:0];
        w_wt = r_rd_task;
        w_wd = r_rd_delta;
        case (r_state)
            S_INS_CMP: begin
                // at the stop point, trim the follower
                if (r_ph && !w_ins_go && r_pos < r_occ) begin
                    w_we = 1'b1;
                    w_wd = r_rd_delta - r_rem;
                end
            end
            S_INS_SHIFT: begin
                if (r_pos == r_slot) begin
                    w_we = 1'b1;
                    w_wt = r_tid;
                    w_wd = r_rem;
                end else if (r_ph) begin
                    w_we = 1'b1;
                end
            end
            S_REM_SHIFT: begin
                if (r_ph) begin
                    w_we = 1'b1;
                    w_wd = r_rd_delta + r_rem;
                end
            end
            S_TICK_CHK: begin
                if (r_ph && r_first) begin
                    w_we = 1'b1;
                    w_wa = '0;
                    w_wd = w_head;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_ovalid <= 1'b0;
            r_ph     <= 1'b0;
            r_pos    <= '0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
                r_out    <= r_res;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_tid   <= i_q_word.task_id;
                        r_rem   <= i_q_word.sleep_ticks;
                        r_pos   <= '0;
                        r_ph    <= 1'b0;
                        r_woke  <= 1'b0;
                        r_first <= 1'b1;
                        r_after <= 1'b0;
                        r_res.woken_task  <= '0;
                        r_res.last_result <= 1'b1;
                        case (i_q_word.req_type)
                            dsq_pkg::REQ_INSERT: begin
                                if (i_q_word.sleep_ticks == '0) begin
                                    r_res.status <= dsq_pkg::ST_ZERO;
                                    r_state <= S_OUT;
                                end else if (r_occ >= Full) begin
                                    r_res.status <= dsq_pkg::ST_FULL;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_INS_CMP;
                                end
                            end
                            dsq_pkg::REQ_CANCEL: r_state <= S_CAN_CMP;
                            dsq_pkg::REQ_TICK:   r_state <= S_TICK_CHK;
                            default:             r_state <= S_IDLE;
                        endcase
                    end
                end
                S_INS_CMP: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (w_ins_go) begin
                        r_rem <= r_rem - r_rd_delta;
                        r_pos <= r_pos + CntW'(1);
                        r_ph  <= 1'b0;
                    end else begin
                        r_slot  <= r_pos;
                        r_pos   <= r_occ;
                        r_ph    <= 1'b0;
                        r_state <= S_INS_SHIFT;
                    end
                end
                S_INS_SHIFT: begin
                    if (r_pos == r_slot) begin
                        r_occ        <= r_occ + CntW'(1);
                        r_res.status <= dsq_pkg::ST_DONE;
                        r_state      <= S_OUT;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph  <= 1'b0;
                        r_pos <= r_pos - CntW'(1);
                    end
                end
                S_CAN_CMP: begin
                    if (r_pos >= r_occ) begin
                        r_res.status <= dsq_pkg::ST_NOT_FOUND;
                        r_state <= S_OUT;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (r_rd_task == r_tid) begin
                        r_rem   <= r_rd_delta;
                        r_ph    <= 1'b0;
                        r_state <= S_REM_SHIFT;
                    end else begin
                        r_ph  <= 1'b0;
                        r_pos <= r_pos + CntW'(1);
                    end
                end
                S_REM_SHIFT: begin
                    if (r_pos + CntW'(1) >= r_occ) begin
                        r_occ <= r_occ - CntW'(1);
                        r_pos <= '0;
                        if (r_after) begin
                            r_state <= S_TICK_CHK;
                        end else begin
                            r_res.status <= dsq_pkg::ST_DONE;
                            r_state <= S_OUT;
                        end
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph  <= 1'b0;
                        r_rem <= '0;   // only the first follower takes the delta
                        r_pos <= r_pos + CntW'(1);
                    end
                end
                S_TICK_CHK: begin
                    if (!r_ph && r_occ != '0) begin
                        r_ph <= 1'b1;
                    end else if (!r_ph || w_head != '0) begin
                        // queue empty or head still asleep: final word
                        r_ph    <= 1'b0;
                        r_first <= 1'b0;
                        r_after <= 1'b0;
                        r_res.status      <= r_woke ? dsq_pkg::ST_WOKEN
                                                    : dsq_pkg::ST_NONE_WOKE;
                        r_res.woken_task  <= r_woke ? r_wtask : '0;
                        r_res.last_result <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_woke) begin
                        // another release follows: held one goes out, not last
                        r_ph    <= 1'b0;
                        r_first <= 1'b0;
                        r_woke  <= 1'b0;
                        r_after <= 1'b1;
                        r_res.status      <= dsq_pkg::ST_WOKEN;
                        r_res.woken_task  <= r_wtask;
                        r_res.last_result <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        // head releases; remove it (zero carried to follower)
                        r_ph    <= 1'b0;
                        r_first <= 1'b0;
                        r_woke  <= 1'b1;
                        r_wtask <= r_rd_task;
                        r_rem   <= '0;
                        r_pos   <= '0;
                        r_after <= 1'b1;
                        r_state <= S_REM_SHIFT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_ph    <= 1'b0;
                        r_state <= r_after ? S_TICK_CHK : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/delta_sleep_queue.sv
// ----------------------------------------------------------------------------
// delta_sleep_queue - sorted delta-list sleep queue of task ids
// Front end queues request words; back end walks the list in a memory.
// ----------------------------------------------------------------------------
// Insert and cancel walk or shift the list one entry at a time through the
// single registered read port; rejects go straight to the result word; a tick
// also removes each released head with a remove shift.
// One request at a time in the back end; the front holds two more words.
// Reset (synchronous, active low) empties the queue; no clearing pass.
module delta_sleep_queue #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  dsq_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output dsq_pkg::t_out_word o_word
);

    logic              w_q_valid;
    logic              w_q_take;
    dsq_pkg::t_in_word w_q_word;

    dsq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_word   (i_word),
        .o_q_valid(w_q_valid),
        .i_q_take (w_q_take),
        .o_q_word (w_q_word)
    );

    dsq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .o_q_take (w_q_take),
        .i_q_word (w_q_word),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_word   (o_word)
    );

endmodule

>>> rtl/dsq_checker.sv
// ----------------------------------------------------------------------------
// dsq_checker - port-level checks for the delta sleep queue
// Watches result words for consistency across time.
// ----------------------------------------------------------------------------
module dsq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input dsq_pkg::t_out_word o_word
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("stalled result word changed");

    a_woken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.status != dsq_pkg::ST_WOKEN |-> o_word.woken_task == '0)
        else $error("woken task set on non-woken word");

    a_only_woken_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_word.last_result |-> o_word.status == dsq_pkg::ST_WOKEN)
        else $error("non-final word that is not a release");

endmodule

bind delta_sleep_queue dsq_checker u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_word (o_word)
);

>>> tb/sv/tb_delta_sleep_queue.sv
// ----------------------------------------------------------------------------
// tb_delta_sleep_queue - self-checking bench for the delta sleep queue
// Directed table then random request words; every result word is checked
// against a behavioural delta list kept in the bench.
// ----------------------------------------------------------------------------
module tb_delta_sleep_queue;

    localparam int Depth = 16;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    dsq_pkg::t_in_word  i_word = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    dsq_pkg::t_out_word o_word;

    delta_sleep_queue #(.QUEUE_DEPTH(Depth)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_word(i_word),
        .o_valid(o_valid), .i_stall(i_stall), .o_word(o_word)
    );

    always #2 i_clk = ~i_clk;

    // bench copy of the delta list
    logic [dsq_pkg::TaskW-1:0]  q_task[$];
    logic [dsq_pkg::TicksW-1:0] q_delta[$];
    dsq_pkg::t_out_word         pending[$];
    dsq_pkg::t_out_word         last_seen;
    int errors = 0;
    int n_words = 0, n_results = 0, n_woken = 0, n_full = 0;
    bit calm = 1'b0;           // set during the stretch with no idling

    task automatic report(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    function automatic dsq_pkg::t_out_word mk(input dsq_pkg::t_status st,
                                              input logic [7:0] t);
        dsq_pkg::t_out_word w;
        w.status = st; w.woken_task = t; w.last_result = 1'b0;
        return w;
    endfunction

    // work out the result words of one request and update the list
    task automatic predict_queue(input dsq_pkg::t_in_word w);
        dsq_pkg::t_out_word res[$];
        int                 pos;
        logic [15:0]        rem;
        dsq_pkg::t_status   st;
        pos = 0;
        rem = w.sleep_ticks;
        case (dsq_pkg::t_req'(w.req_type))
            dsq_pkg::REQ_INSERT: begin
                if (w.sleep_ticks == 0) st = dsq_pkg::ST_ZERO;
                else if (q_task.size() >= Depth) st = dsq_pkg::ST_FULL;
                else begin
                    while (pos < q_task.size() && q_delta[pos] < rem) begin
                        rem -= q_delta[pos];
                        pos++;
                    end
                    if (pos < q_task.size()) q_delta[pos] -= rem;
                    q_task.insert(pos, w.task_id);
                    q_delta.insert(pos, rem);
                    st = dsq_pkg::ST_DONE;
                end
                res.push_back(mk(st, '0));
            end
            dsq_pkg::REQ_CANCEL: begin
                st = dsq_pkg::ST_NOT_FOUND;
                for (pos = 0; pos < q_task.size(); pos++) begin
                    if (q_task[pos] == w.task_id) begin
                        if (pos + 1 < q_task.size()) q_delta[pos+1] += q_delta[pos];
                        q_task.delete(pos);
                        q_delta.delete(pos);
                        st = dsq_pkg::ST_DONE;
                        break;
                    end
                end
                res.push_back(mk(st, '0));
            end
            dsq_pkg::REQ_TICK: begin
                if (q_task.size() > 0 && q_delta[0] > 0) q_delta[0]--;
                while (q_task.size() > 0 && q_delta[0] == 0) begin
                    res.push_back(mk(dsq_pkg::ST_WOKEN, q_task[0]));
                    void'(q_task.pop_front());
                    void'(q_delta.pop_front());
                end
                if (res.size() == 0) res.push_back(mk(dsq_pkg::ST_NONE_WOKE, '0));
            end
            default: ;   // unused code: no result
        endcase
        if (res.size() > 0) res[res.size()-1].last_result = 1'b1;
        foreach (res[k]) pending.push_back(res[k]);
    endtask

    // send one word; returns at the falling edge after acceptance
    task automatic send(input dsq_pkg::t_req r, input logic [7:0] t,
                        input logic [15:0] n);
        while (!calm && $urandom_range(99) < 11) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_word  <= '{req_type: r, task_id: t, sleep_ticks: n};
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_queue(i_word);
        n_words++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (8 * Depth) @(negedge i_clk);
    endtask

    // receiving side: random stall, check on acceptance
    always @(negedge i_clk) i_stall <= (!calm && $urandom_range(99) < 11);

    always @(posedge i_clk) begin
        dsq_pkg::t_out_word e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            last_seen = o_word;
            if (o_word.status == dsq_pkg::ST_WOKEN) n_woken++;
            if (o_word.status == dsq_pkg::ST_FULL) n_full++;
            if (pending.size() == 0) report($sformatf("unexpected word %p", o_word));
            else begin
                e = pending.pop_front();
                if (o_word.status !== e.status)
                    report($sformatf("status %0d, want %0d", o_word.status, e.status));
                if (o_word.woken_task !== e.woken_task)
                    report($sformatf("task %0d, want %0d", o_word.woken_task,
                                     e.woken_task));
                if (o_word.last_result !== e.last_result)
                    report($sformatf("last %0b, want %0b", o_word.last_result,
                                     e.last_result));
            end
        end
    end

    // directed table: request, id, ticks, typed status check
    typedef struct {
        dsq_pkg::t_req    r;
        logic [7:0]       t;
        logic [15:0]      n;
        bit               chk;
        dsq_pkg::t_status want;
    } t_row;

    t_row rows[] = '{
        '{dsq_pkg::REQ_TICK,   8'd0,  16'd0,    1'b1, dsq_pkg::ST_NONE_WOKE}, // empty
        '{dsq_pkg::REQ_CANCEL, 8'd9,  16'd0,    1'b1, dsq_pkg::ST_NOT_FOUND},
        '{dsq_pkg::REQ_INSERT, 8'd1,  16'd0,    1'b1, dsq_pkg::ST_ZERO},
        '{dsq_pkg::REQ_NONE,   8'hFF, 16'hFFFF, 1'b0, dsq_pkg::ST_DONE},    // ignored
        '{dsq_pkg::REQ_INSERT, 8'hFF, 16'hFFFF, 1'b1, dsq_pkg::ST_DONE},
        '{dsq_pkg::REQ_INSERT, 8'h00, 16'd1,    1'b0, dsq_pkg::ST_DONE},
        '{dsq_pkg::REQ_INSERT, 8'h55, 16'd3,    1'b0, dsq_pkg::ST_DONE},
        '{dsq_pkg::REQ_INSERT, 8'hAA, 16'd3,    1'b0, dsq_pkg::ST_DONE},    // goes ahead
        '{dsq_pkg::REQ_INSERT, 8'h55, 16'd5,    1'b0, dsq_pkg::ST_DONE},    // same id
        '{dsq_pkg::REQ_CANCEL, 8'h55, 16'd0,    1'b0, dsq_pkg::ST_DONE},    // first only
        '{dsq_pkg::REQ_TICK,   8'd0,  16'd0,    1'b0, dsq_pkg::ST_DONE},
        '{dsq_pkg::REQ_TICK,   8'd0,  16'd0,    1'b0, dsq_pkg::ST_DONE},
        '{dsq_pkg::REQ_TICK,   8'd0,  16'd0,    1'b0, dsq_pkg::ST_DONE},    // one wakes
        '{dsq_pkg::REQ_CANCEL, 8'hFF, 16'd0,    1'b0, dsq_pkg::ST_DONE},
        '{dsq_pkg::REQ_TICK,   8'd0,  16'd0,    1'b0, dsq_pkg::ST_DONE}
    };

    initial begin
        int kind;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) begin
            send(rows[k].r, rows[k].t, rows[k].n);
            if (rows[k].chk) begin
                wait_drained();
                if (last_seen.status !== rows[k].want)
                    report($sformatf("row %0d: status %0d, typed %0d", k,
                                     last_seen.status, rows[k].want));
            end
        end
        // fill to full, then one over; all wake on the second of two ticks after a pause
        for (int k = 0; k < Depth; k++) send(dsq_pkg::REQ_INSERT, 8'(k), 16'd2);
        send(dsq_pkg::REQ_INSERT, 8'd200, 16'd7);
        wait_drained();
        send(dsq_pkg::REQ_TICK, 8'd0, 16'd0);
        send(dsq_pkg::REQ_TICK, 8'd0, 16'd0);

        for (int k = 0; k < 330; k++) begin
            calm = (k >= 120 && k < 180);
            if (k == 250) wait_drained();
            kind = $urandom_range(99);
            if (kind < 45)
                send(dsq_pkg::REQ_INSERT, 8'($urandom_range(0, 15)),
                     ($urandom_range(9) == 0) ? 16'($urandom) :
                     ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 6)));
            else if (kind < 60)
                send(dsq_pkg::REQ_CANCEL, ($urandom_range(7) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(0, 15)),
                     16'($urandom));
            else if (kind < 97)
                send(dsq_pkg::REQ_TICK, 8'($urandom), 16'($urandom));
            else send(dsq_pkg::REQ_NONE, 8'($urandom), 16'($urandom));
        end
        calm = 1'b0;
        wait_drained();

        $display("Covered %0d request words, %0d result words (%0d woken, %0d full).",
                 n_words, n_results, n_woken, n_full);
        if (errors == 0 && pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
